// File: src/pwsmh_pkg.sv
// Shared types, constants and helpers for the per-word symbol maximum histogram.
package pwsmh_pkg;

    localparam int SYMBOL_COUNT = 222;
    localparam int FIRST_CODE   = 33;
    localparam int COUNT_BITS   = 8;

    localparam int CMD_W  = 2;
    localparam int CODE_W = 8;
    localparam int OUT_W  = 8;
    localparam int IDX_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int TOT_W  = $clog2(SYMBOL_COUNT + 1);

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [IDX_W-1:0]      idx_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_CHAR  = 2'd0,
        CMD_EOW   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef struct packed {
        logic ok;
        idx_t idx;
    } idx_info_t;

    // Access request into the count stores.
    typedef struct packed {
        logic   rd_en;
        idx_t   rd_addr;
        idx_t   wr_addr;
        logic   wc_we;
        count_t wc_wdata;
        logic   gm_we;
        count_t gm_wdata;
    } hist_req_t;

    function automatic idx_info_t code_index(input logic [CODE_W-1:0] code);
        logic [CODE_W:0] diff;
        idx_info_t       info;
        diff     = {1'b0, code} - (CODE_W + 1)'(FIRST_CODE);
        info.ok  = (code >= CODE_W'(FIRST_CODE)) && (diff < (CODE_W + 1)'(SYMBOL_COUNT));
        info.idx = diff[IDX_W-1:0];
        return info;
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(input count_t c);
        if (32'(c) > 32'd255) begin
            return '1;
        end
        return OUT_W'(c);
    endfunction

endpackage

// File: src/per_word_symbol_max_histogram_top.sv
// Per-word symbol maximum histogram: top level with command sequencer.
//
// Each input transaction carries a command and a byte code. A character
// (codes 33..254 counted, others dropped) has its word count read from
// memory in S_IDLE; S_CHAR writes back the incremented, saturating count
// and, on its first hit in the word, appends the symbol to the touched
// list. A read yields one result transaction with the global maximum
// (0 for uncounted codes); a new transaction is taken while that result
// waits on m_ready, but a second read stalls until the output register
// is free. End of word walks the touched list through S_WLOOK and S_WUPD
// for each distinct symbol, as set by the single read port of the count
// memories: S_WLOOK looks up the word and global counts, S_WUPD writes
// the larger back and zeroes the word count. Both count stores are zeroed
// by a clearing pass that writes one entry per cycle: after reset before
// s_ready first rises, and for a clear command.
module per_word_symbol_max_histogram_top import pwsmh_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CMD_W-1:0]  s_command,
    input  logic [CODE_W-1:0] s_symbol_code,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CODE_W-1:0] m_read_code,
    output logic [OUT_W-1:0]  m_max_count
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHAR  = 6'b000010,
        S_READ  = 6'b000100,
        S_WLOOK = 6'b001000,
        S_WUPD  = 6'b010000,
        S_CLR   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CODE_W-1:0] code_reg, code_next;
    idx_t              idx_reg, idx_next;
    logic              ok_reg, ok_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [TOT_W-1:0]  walk_i_reg, walk_i_next;
    logic [TOT_W-1:0]  walk_i_inc;
    idx_t              sym_reg, sym_next;
    idx_t              clr_idx_reg, clr_idx_next;

    logic              m_valid_reg, m_valid_next;
    logic [CODE_W-1:0] m_code_reg, m_code_next;
    logic [OUT_W-1:0]  m_count_reg, m_count_next;

    // touched list memory
    idx_t tl_mem [SYMBOL_COUNT];
    idx_t tl_q_reg;
    logic tl_we;
    logic tl_re;
    idx_t tl_waddr;
    idx_t tl_raddr;

    hist_req_t req;
    count_t    wc_rd;
    count_t    gm_rd;
    count_t    wc_inc;
    idx_info_t ci;

    pwsmh_hist u_hist (
        .aclk    (aclk),
        .req     (req),
        .wc_rd   (wc_rd),
        .gm_rd   (gm_rd)
    );

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_read_code = m_code_reg;
    assign m_max_count = m_count_reg;

    assign ci         = code_index(s_symbol_code);
    assign wc_inc     = (wc_rd == '1) ? wc_rd : wc_rd + count_t'(1);
    assign walk_i_inc = walk_i_reg + TOT_W'(1);
    assign tl_waddr   = total_reg[IDX_W-1:0];

    always_comb begin
        state_next   = state_reg;
        code_next    = code_reg;
        idx_next     = idx_reg;
        ok_next      = ok_reg;
        total_next   = total_reg;
        walk_i_next  = walk_i_reg;
        sym_next     = sym_reg;
        clr_idx_next = clr_idx_reg;
        m_valid_next = m_valid_reg;
        m_code_next  = m_code_reg;
        m_count_next = m_count_reg;
        req          = '0;
        tl_we        = 1'b0;
        tl_re        = 1'b0;
        tl_raddr     = walk_i_inc[IDX_W-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    code_next = s_symbol_code;
                    idx_next  = ci.idx;
                    ok_next   = ci.ok;
                    unique case (cmd_t'(s_command))
                        CMD_CHAR: begin
                            if (ci.ok) begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = ci.idx;
                                state_next  = S_CHAR;
                            end
                        end
                        CMD_EOW: begin
                            if (total_reg != '0) begin
                                tl_re       = 1'b1;
                                tl_raddr    = '0;
                                walk_i_next = '0;
                                state_next  = S_WLOOK;
                            end
                        end
                        CMD_READ: begin
                            req.rd_en   = ci.ok;
                            req.rd_addr = ci.idx;
                            state_next  = S_READ;
                        end
                        CMD_CLEAR: begin
                            total_next   = '0;
                            clr_idx_next = '0;
                            state_next   = S_CLR;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHAR: begin
                req.wc_we    = 1'b1;
                req.wr_addr  = idx_reg;
                req.wc_wdata = wc_inc;
                // first hit of this symbol in the word
                if ((wc_rd == '0) && (total_reg < TOT_W'(SYMBOL_COUNT))) begin
                    tl_we      = 1'b1;
                    total_next = total_reg + TOT_W'(1);
                end
                state_next = S_IDLE;
            end
            S_READ: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_code_next  = code_reg;
                    m_count_next = ok_reg ? sat_out(gm_rd) : '0;
                    state_next   = S_IDLE;
                end
            end
            S_WLOOK: begin
                sym_next    = tl_q_reg;
                req.rd_en   = 1'b1;
                req.rd_addr = tl_q_reg;
                // prefetch next touched entry
                if (walk_i_inc < total_reg) begin
                    tl_re = 1'b1;
                end
                state_next = S_WUPD;
            end
            S_WUPD: begin
                req.wr_addr  = sym_reg;
                req.wc_we    = 1'b1;
                req.wc_wdata = '0;
                req.gm_wdata = wc_rd;
                if (wc_rd > gm_rd) begin
                    req.gm_we = 1'b1;
                end
                if (walk_i_inc == total_reg) begin
                    total_next = '0;
                    state_next = S_IDLE;
                end else begin
                    walk_i_next = walk_i_inc;
                    state_next  = S_WLOOK;
                end
            end
            S_CLR: begin
                // zero one entry of both count stores per cycle
                req.wr_addr  = clr_idx_reg;
                req.wc_we    = 1'b1;
                req.wc_wdata = '0;
                req.gm_we    = 1'b1;
                req.gm_wdata = '0;
                if (clr_idx_reg == idx_t'(SYMBOL_COUNT - 1)) begin
                    clr_idx_next = '0;
                    state_next   = S_IDLE;
                end else begin
                    clr_idx_next = clr_idx_reg + idx_t'(1);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (tl_we) begin
            tl_mem[tl_waddr] <= idx_reg;
        end
        if (tl_re) begin
            tl_q_reg <= tl_mem[tl_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            total_reg   <= '0;
            walk_i_reg  <= '0;
            clr_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            walk_i_reg  <= walk_i_next;
            clr_idx_reg <= clr_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg    <= code_next;
        idx_reg     <= idx_next;
        ok_reg      <= ok_next;
        sym_reg     <= sym_next;
        m_code_reg  <= m_code_next;
        m_count_reg <= m_count_next;
    end

    // touched list never holds more entries than there are symbols
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= TOT_W'(SYMBOL_COUNT))
        else $error("touched total beyond symbol count");

    // walk stays inside the filled part of the touched list
    a_walk_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WUPD || state_reg == S_WLOOK) |-> walk_i_reg < total_reg)
        else $error("walk index outside touched list");

    // clear empties the touched list
    a_clear_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == CMD_CLEAR) |=> total_reg == '0)
        else $error("clear left touched entries");

    // a read leaving S_READ always lands in the output register
    a_read_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("read result lost");

endmodule

// File: src/pwsmh_hist.sv
// Word count and global maximum memories.
module pwsmh_hist import pwsmh_pkg::*; (
    input  logic      aclk,
    input  hist_req_t req,
    output count_t    wc_rd,
    output count_t    gm_rd
);

    count_t wc_mem [SYMBOL_COUNT];
    count_t gm_mem [SYMBOL_COUNT];

    count_t wc_q_reg;
    count_t gm_q_reg;

    always_ff @(posedge aclk) begin
        if (req.wc_we) begin
            wc_mem[req.wr_addr] <= req.wc_wdata;
        end
        if (req.gm_we) begin
            gm_mem[req.wr_addr] <= req.gm_wdata;
        end
        if (req.rd_en) begin
            wc_q_reg <= wc_mem[req.rd_addr];
            gm_q_reg <= gm_mem[req.rd_addr];
        end
    end

    assign wc_rd = wc_q_reg;
    assign gm_rd = gm_q_reg;

endmodule

// File: bench/tb_per_word_symbol_max_histogram_top.sv
// Self-checking testbench for the per-word symbol maximum histogram top level.
`timescale 1ns / 1ps

module tb_per_word_symbol_max_histogram_top;
    import pwsmh_pkg::*;

    // One command transaction on the input channel.
    typedef struct packed {
        cmd_t              cmd;
        logic [CODE_W-1:0] code;
    } symbol_cmd_t;

    // One read reply on the result channel.
    typedef struct packed {
        logic [CODE_W-1:0] read_code;
        logic [OUT_W-1:0]  max_count;
    } peak_reply_t;

    localparam int RAND_TARGET   = 1400;   // rough item count for the random part
    localparam int STALL_CYCLES  = 600;    // long receiver hold-off
    localparam int STALL_AT      = 40;     // reply count that starts the hold-off
    localparam int IDLE_LIMIT    = 4000;   // cycles with no transaction before giving up
    localparam int DRAIN_CYCLES  = 50;
    localparam int MAX_REPORTS   = 10;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [CMD_W-1:0]  s_command = CMD_CHAR;
    logic [CODE_W-1:0] s_symbol_code = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [CODE_W-1:0] m_read_code;
    logic [OUT_W-1:0]  m_max_count;

    per_word_symbol_max_histogram_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_symbol_code (s_symbol_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_code   (m_read_code),
        .m_max_count   (m_max_count)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Histogram predictor state
    // ------------------------------------------------------------------
    count_t word_tally [SYMBOL_COUNT];   // counts within the current word
    count_t peak_count [SYMBOL_COUNT];   // largest per-word count so far
    int     word_symbols [$];            // symbol slots first hit in this word

    symbol_cmd_t cmd_backlog [$];        // commands not yet put on the bus
    peak_reply_t expected_peaks [$];     // replies owed by the block, oldest first

    int issued_items  = 0;
    int seen_replies  = 0;
    int mismatch_hits = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    // Apply one accepted command to the predictor; a read owes one reply.
    task automatic tally_command(input cmd_t cmd, input logic [CODE_W-1:0] code);
        bit          counted;
        int          slot;
        peak_reply_t reply;
        counted = (code >= FIRST_CODE) && (int'(code) - FIRST_CODE < SYMBOL_COUNT);
        slot    = counted ? int'(code) - FIRST_CODE : 0;
        case (cmd)
            CMD_CHAR: begin
                if (counted) begin
                    if (word_tally[slot] == '0) begin
                        word_symbols.push_back(slot);
                    end
                    if (word_tally[slot] != '1) begin
                        word_tally[slot] = word_tally[slot] + 1'b1;
                    end
                end
            end
            CMD_EOW: begin
                // Merge the word into the peaks and drop its counts.
                foreach (word_symbols[i]) begin
                    if (word_tally[word_symbols[i]] > peak_count[word_symbols[i]]) begin
                        peak_count[word_symbols[i]] = word_tally[word_symbols[i]];
                    end
                    word_tally[word_symbols[i]] = '0;
                end
                word_symbols.delete();
            end
            CMD_READ: begin
                reply.read_code = code;
                reply.max_count = '0;
                if (counted) begin
                    reply.max_count = (int'(peak_count[slot]) > 255) ? '1
                                                                     : OUT_W'(peak_count[slot]);
                end
                expected_peaks.push_back(reply);
            end
            default: begin
                foreach (word_tally[i]) begin
                    word_tally[i] = '0;
                    peak_count[i] = '0;
                end
                word_symbols.delete();
            end
        endcase
    endtask

    task automatic flag_mismatch(input string what, input int want, input int got);
        mismatch_hits++;
        if (mismatch_hits <= MAX_REPORTS) begin
            $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    task automatic queue_cmd(input cmd_t cmd, input int code);
        symbol_cmd_t item;
        item.cmd  = cmd;
        item.code = CODE_W'(code);
        cmd_backlog.push_back(item);
    endtask

    // Extremes of the code range, ignored codes, empty word, clear.
    task automatic build_directed();
        // reads straight out of reset: everything zero
        queue_cmd(CMD_READ, 0);
        queue_cmd(CMD_READ, 32);
        queue_cmd(CMD_READ, 33);
        queue_cmd(CMD_READ, 254);
        queue_cmd(CMD_READ, 255);
        // first word: repeats, both edge codes, codes that are dropped
        queue_cmd(CMD_CHAR, 33);
        queue_cmd(CMD_CHAR, 33);
        queue_cmd(CMD_CHAR, 254);
        queue_cmd(CMD_CHAR, 0);
        queue_cmd(CMD_CHAR, 32);
        queue_cmd(CMD_CHAR, 255);
        queue_cmd(CMD_CHAR, 128);
        queue_cmd(CMD_EOW, 0);
        queue_cmd(CMD_READ, 33);
        queue_cmd(CMD_READ, 254);
        queue_cmd(CMD_READ, 128);
        queue_cmd(CMD_READ, 0);
        // empty word must not disturb the peaks
        queue_cmd(CMD_EOW, 255);
        queue_cmd(CMD_READ, 33);
        queue_cmd(CMD_CLEAR, 170);
        queue_cmd(CMD_READ, 33);
        queue_cmd(CMD_READ, 254);
        queue_cmd(CMD_CHAR, 33);
        queue_cmd(CMD_EOW, 85);
        queue_cmd(CMD_READ, 33);
    endtask

    function automatic int pick_counted_code();
        int roll;
        roll = $urandom_range(19);
        if (roll == 0) return FIRST_CODE;
        if (roll == 1) return FIRST_CODE + SYMBOL_COUNT - 1;
        return $urandom_range(FIRST_CODE + SYMBOL_COUNT - 1, FIRST_CODE);
    endfunction

    // Mostly well-formed words over small alphabets, then reads; some noise.
    task automatic build_random_traffic();
        int letters [8];
        int n_letters;
        int word_len;
        int roll;
        int reps;
        int tmp;
        int j;
        int perm [SYMBOL_COUNT];
        bit sat_done;
        bit full_done;
        int stop_at;
        sat_done  = 1'b0;
        full_done = 1'b0;
        n_letters = 4;
        for (int i = 0; i < 8; i++) letters[i] = pick_counted_code();
        stop_at = cmd_backlog.size() + RAND_TARGET;
        while (cmd_backlog.size() < stop_at) begin
            roll = $urandom_range(99);
            if (!sat_done && cmd_backlog.size() > 300) begin
                // one symbol far past the count ceiling, then again to show it stays put
                sat_done = 1'b1;
                reps = $urandom_range(300, 256);
                repeat (reps) queue_cmd(CMD_CHAR, letters[0]);
                queue_cmd(CMD_EOW, $urandom_range(255));
                queue_cmd(CMD_READ, letters[0]);
                repeat (3) queue_cmd(CMD_CHAR, letters[0]);
                queue_cmd(CMD_EOW, $urandom_range(255));
                queue_cmd(CMD_READ, letters[0]);
            end else if (!full_done && cmd_backlog.size() > 700) begin
                // every counted symbol in one word: touched list completely full
                full_done = 1'b1;
                for (int i = 0; i < SYMBOL_COUNT; i++) perm[i] = i;
                for (int i = SYMBOL_COUNT - 1; i > 0; i--) begin
                    j = $urandom_range(i);
                    tmp = perm[i];
                    perm[i] = perm[j];
                    perm[j] = tmp;
                end
                for (int i = 0; i < SYMBOL_COUNT; i++) begin
                    queue_cmd(CMD_CHAR, FIRST_CODE + perm[i]);
                    if ($urandom_range(3) == 0) queue_cmd(CMD_CHAR, FIRST_CODE + perm[i]);
                end
                queue_cmd(CMD_EOW, $urandom_range(255));
                queue_cmd(CMD_READ, FIRST_CODE);
                queue_cmd(CMD_READ, FIRST_CODE + SYMBOL_COUNT - 1);
                repeat (4) queue_cmd(CMD_READ, pick_counted_code());
            end else if (roll < 60) begin
                if ($urandom_range(9) < 3) begin
                    n_letters = $urandom_range(8, 1);
                    for (int i = 0; i < 8; i++) letters[i] = pick_counted_code();
                end
                word_len = $urandom_range(24, 1);
                repeat (word_len) begin
                    if ($urandom_range(99) < 6) queue_cmd(CMD_CHAR, $urandom_range(255));
                    else queue_cmd(CMD_CHAR, letters[$urandom_range(n_letters - 1)]);
                end
                // now and then the word runs on into the next one
                if ($urandom_range(9) != 0) queue_cmd(CMD_EOW, $urandom_range(255));
                repeat ($urandom_range(3)) begin
                    if ($urandom_range(9) < 7) queue_cmd(CMD_READ, letters[$urandom_range(7)]);
                    else queue_cmd(CMD_READ, $urandom_range(255));
                end
            end else if (roll < 75) begin
                repeat ($urandom_range(5, 1)) begin
                    if ($urandom_range(1)) queue_cmd(CMD_READ, letters[$urandom_range(7)]);
                    else queue_cmd(CMD_READ, $urandom_range(255));
                end
            end else if (roll < 80) begin
                queue_cmd(CMD_CLEAR, $urandom_range(255));
            end else begin
                repeat ($urandom_range(3, 1)) begin
                    queue_cmd(cmd_t'($urandom_range(3)), $urandom_range(255));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued commands, predicts on each accepted transaction.
    // A stretch of items goes out back to back with no gaps.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : cmd_driver
        bit          offering;
        bit          steady;
        symbol_cmd_t item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            offering = s_valid;
            if (s_valid && s_ready) begin
                tally_command(cmd_t'(s_command), s_symbol_code);
                offering = 1'b0;
            end
            steady = (issued_items >= 500) && (issued_items < 800);
            if (!offering && cmd_backlog.size() != 0 && (steady || $urandom_range(99) >= 10)) begin
                item = cmd_backlog.pop_front();
                s_command     <= item.cmd;
                s_symbol_code <= item.code;
                issued_items++;
                offering = 1'b1;
            end
            s_valid <= offering;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes replies, checks them against the oldest expectation,
    // and drives m_ready. Once, a long hold-off backs the block up until
    // it stops taking commands.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : reply_monitor
        peak_reply_t want;
        bit          steady;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                seen_replies++;
                if (expected_peaks.size() == 0) begin
                    flag_mismatch("reply with nothing owed, max_count", -1, m_max_count);
                end else begin
                    want = expected_peaks.pop_front();
                    if (m_read_code !== want.read_code) begin
                        flag_mismatch("read_code", want.read_code, m_read_code);
                    end
                    if (m_max_count !== want.max_count) begin
                        flag_mismatch("max_count", want.max_count, m_max_count);
                    end
                end
                if (!hold_done && seen_replies == STALL_AT) begin
                    hold_done = 1'b1;
                    hold_left = STALL_CYCLES;
                end
            end
            steady = (seen_replies >= 60) && (seen_replies < 100);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 10);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transaction on either channel.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("per_word_symbol_max_histogram_top: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build stimulus, reset, drain, verdict.
    // ------------------------------------------------------------------
    initial begin
        foreach (word_tally[i]) begin
            word_tally[i] = '0;
            peak_count[i] = '0;
        end
        build_directed();
        build_random_traffic();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // sampled on the falling edge, clear of the driver's updates
        @(negedge aclk);
        while (cmd_backlog.size() != 0 || s_valid) @(negedge aclk);
        while (expected_peaks.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_hits == 0 && expected_peaks.size() == 0) begin
            $display("per_word_symbol_max_histogram_top: match");
        end else begin
            $display("per_word_symbol_max_histogram_top: mismatch");
        end
        $finish;
    end

endmodule
